// File: hw/rtl/bile_pkg.sv
// Shared constants for the bounded integer list engine: field widths,
// action codes and the default capacity. Depends on nothing.
package bile_pkg;

  localparam int unsigned DEF_CAPACITY = 64;

  localparam int unsigned ACTION_W = 3;
  localparam int unsigned VALUE_W  = 32;
  localparam int unsigned POS_W    = 7;

  localparam logic [ACTION_W-1:0] ACT_PUSH   = 3'd0;
  localparam logic [ACTION_W-1:0] ACT_INSERT = 3'd1;
  localparam logic [ACTION_W-1:0] ACT_REMOVE = 3'd2;
  localparam logic [ACTION_W-1:0] ACT_SEARCH = 3'd3;
  localparam logic [ACTION_W-1:0] ACT_CLEAR  = 3'd4;

endpackage

// File: hw/rtl/bile_if.sv
// Valid/ready channel interfaces for the list engine: one for requests,
// one for results. Depends on bile_pkg for the field widths.
interface bile_in_if;
  import bile_pkg::*;

  logic                       valid;
  logic                       ready;
  logic [ACTION_W-1:0]        action;
  logic signed [VALUE_W-1:0]  value;

  modport source (output valid, output action, output value, input ready);
  modport sink   (input valid, input action, input value, output ready);
endinterface

interface bile_out_if;
  import bile_pkg::*;

  logic               valid;
  logic               ready;
  logic               found;
  logic [POS_W-1:0]   position;
  logic [POS_W-1:0]   entry_count;
  logic               is_empty;
  logic               rejected;

  modport source (output valid, output found, output position, output entry_count,
                  output is_empty, output rejected, input ready);
  modport sink   (input valid, input found, input position, input entry_count,
                  input is_empty, input rejected, output ready);
endinterface

// File: hw/rtl/bile_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing.
module bile_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: hw/rtl/bounded_integer_list_engine_top.sv
// Top level of the bounded integer list engine: sequencer, scan datapath
// and result register. Depends on bile_pkg, bile_if and bile_ram.
//
//  Channel  Direction  Handshake        Payload
//  -------  ---------  ---------------  --------------------------------------------
//  req      in         valid / ready    action[2:0], value[31:0] signed
//  rsp      out        valid / ready    found, position[6:0], entry_count[6:0],
//                                       is_empty, rejected
//
// Push, insert, remove and search walk the stored entries once, one entry per
// cycle through the single read port of the entry RAM, before the sequencer
// moves to S_DONE to load the result register. Clear, a rejected push or
// insert and unused action codes skip the scan and go straight to S_DONE.
// The block takes one item at a time; req.ready is high only while the
// sequencer is idle. A result waiting on rsp does not hold off the next request,
// but that request's result then waits in S_DONE, with req.ready low, until rsp
// takes the first. Reset clears the count and control state; the entry RAM is
// not cleared, since only entries below the count are ever read.
module bounded_integer_list_engine_top #(
  parameter int unsigned CAPACITY = bile_pkg::DEF_CAPACITY
) (
  input logic         clk,
  input logic         rst,
  bile_in_if.sink     req,
  bile_out_if.source  rsp
);
  import bile_pkg::*;

  // Address width of the entry RAM and width of a count that can reach CAPACITY.
  localparam int unsigned AW = $clog2(CAPACITY);
  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_DONE = 2'd2;

  logic [1:0]                state;
  logic [ACTION_W-1:0]       act;
  logic signed [VALUE_W-1:0] val;
  logic [CW-1:0]             count;

  // Scan pointer issues reads; pv/pidx track the read whose data is on rdata.
  logic [CW-1:0]             rd_ptr;
  logic                      pv;
  logic [AW-1:0]             pidx;

  logic                      found;
  logic                      placed;
  logic                      rejected;
  logic [CW-1:0]             pos;
  logic [VALUE_W-1:0]        carry;

  // Result register.
  logic                      out_valid;
  logic                      out_found;
  logic [POS_W-1:0]          out_position;
  logic [POS_W-1:0]          out_count;
  logic                      out_empty;
  logic                      out_rejected;

  // Entry RAM ports.
  logic                      we;
  logic [AW-1:0]             waddr;
  logic [VALUE_W-1:0]        wdata;
  logic                      re;
  logic [VALUE_W-1:0]        rdata;

  logic                      is_ins;
  logic                      issue;
  logic                      fin;
  logic                      lt;
  logic                      hit;
  logic                      take_slot;
  logic                      slot_free;

  bile_ram #(
    .WIDTH (VALUE_W),
    .DEPTH (CAPACITY)
  ) u_entries (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (re),
    .raddr (rd_ptr[AW-1:0]),
    .rdata (rdata)
  );

  assign is_ins    = (act == ACT_PUSH) || (act == ACT_INSERT);
  assign issue     = (state == S_SCAN) && (rd_ptr != count);
  assign fin       = (state == S_SCAN) && (rd_ptr == count) && !pv;
  assign lt        = $signed(rdata) < val;
  assign hit       = rdata == val;
  // A push takes the head slot; an insert takes the first slot not below val.
  assign take_slot = !placed && ((act == ACT_PUSH) || !lt);
  assign slot_free = !out_valid || rsp.ready;
  assign re        = issue;

  // Write port. An insert ripples forward: once the new value is placed, each
  // later entry is rewritten with its predecessor, and the last one lands at
  // the old count. A remove moves every entry after the match down by one.
  always_comb begin
    we    = 1'b0;
    waddr = pidx;
    wdata = val;
    if ((state == S_SCAN) && pv) begin
      if (is_ins) begin
        if (placed) begin
          we    = 1'b1;
          wdata = carry;
        end else if (take_slot) begin
          we    = 1'b1;
        end
      end else if ((act == ACT_REMOVE) && found) begin
        we    = 1'b1;
        waddr = pidx - 1'b1;
        wdata = rdata;
      end
    end
    if (fin && is_ins) begin
      we    = 1'b1;
      waddr = count[AW-1:0];
      wdata = placed ? carry : val;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      pv        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      pv <= issue;
      if (issue) begin
        rd_ptr <= rd_ptr + 1'b1;
        pidx   <= rd_ptr[AW-1:0];
      end

      if ((state == S_DONE) && slot_free) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (req.valid) begin
            act      <= req.action;
            val      <= req.value;
            found    <= 1'b0;
            placed   <= 1'b0;
            rejected <= 1'b0;
            pos      <= count;
            rd_ptr   <= '0;
            unique case (req.action) inside
              ACT_PUSH, ACT_INSERT: begin
                if (count == CAP_C) begin
                  rejected <= 1'b1;
                  state    <= S_DONE;
                end else begin
                  state    <= S_SCAN;
                end
              end
              ACT_REMOVE, ACT_SEARCH: begin
                state <= S_SCAN;
              end
              ACT_CLEAR: begin
                count <= '0;
                pos   <= '0;
                state <= S_DONE;
              end
              default: begin
                state <= S_DONE;
              end
            endcase
          end
        end

        S_SCAN: begin
          if (pv) begin
            if (is_ins) begin
              if (placed) begin
                carry <= rdata;
              end else if (take_slot) begin
                placed <= 1'b1;
                pos    <= CW'(pidx);
                carry  <= rdata;
              end
            end else if (!found && hit) begin
              found <= 1'b1;
              pos   <= CW'(pidx);
            end
          end
          if (fin) begin
            if (is_ins) begin
              count <= count + 1'b1;
            end else if ((act == ACT_REMOVE) && found) begin
              count <= count - 1'b1;
            end
            state <= S_DONE;
          end
        end

        S_DONE: begin
          if (slot_free) begin
            out_found    <= found;
            out_position <= POS_W'(pos);
            out_count    <= POS_W'(count);
            out_empty    <= count == '0;
            out_rejected <= rejected;
            state        <= S_IDLE;
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign req.ready       = state == S_IDLE;
  assign rsp.valid       = out_valid;
  assign rsp.found       = out_found;
  assign rsp.position    = out_position;
  assign rsp.entry_count = out_count;
  assign rsp.is_empty    = out_empty;
  assign rsp.rejected    = out_rejected;

  // The list never grows past its capacity.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CAP_C)
    else $error("entry count exceeds capacity");

  // The scan pointer never runs past the entries held.
  a_ptr_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN) |-> (rd_ptr <= count))
    else $error("scan pointer beyond count");

  // During a scan the count changes only at its end, not in the middle of one.
  a_count_hold: assert property (@(posedge clk) disable iff (rst)
    ((state == S_SCAN) && !fin) |=> (count == $past(count)))
    else $error("count changed during scan");

  // A rejected request leaves the list alone and reports the count as position.
  a_reject: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && rsp.rejected) |-> (!rsp.found && (rsp.position == rsp.entry_count)))
    else $error("rejected result inconsistent");

endmodule

// File: tb/tb_bounded_integer_list_engine_top.sv
// Self-checking testbench for the bounded integer list engine: a request-level list
// predictor, valid/ready drivers with random idling and a result checker.
// Depends on bile_pkg, bile_if and bounded_integer_list_engine_top.
module tb_bounded_integer_list_engine_top;
  timeunit 1ns;
  timeprecision 1ps;
  import bile_pkg::*;

  localparam int unsigned LIST_CAP = DEF_CAPACITY;
  localparam int unsigned RANDOM_ITEMS = 1550;
  localparam int unsigned HOLD_CYCLES = 400;
  localparam int unsigned SETTLE_CYCLES = LIST_CAP + 16;
  localparam int unsigned LIMIT_CYCLES = 1_000_000;
  localparam int unsigned MAX_REPORTS = 10;

  // Action codes 5 to 7 are not used by the block and must act as a no-op.
  localparam logic [ACTION_W-1:0] ACT_SPARE_FIRST = 3'd5;
  localparam logic [ACTION_W-1:0] ACT_SPARE_LAST  = 3'd7;

  localparam logic signed [VALUE_W-1:0] VAL_MAX = 32'sh7fff_ffff;
  localparam logic signed [VALUE_W-1:0] VAL_MIN = 32'sh8000_0000;

  // One result item as it leaves the block.
  typedef struct packed {
    logic             found;
    logic [POS_W-1:0] position;
    logic [POS_W-1:0] entry_count;
    logic             is_empty;
    logic             rejected;
  } list_result_t;

  // Patterns that the receiver cycles through when it is not held off.
  typedef enum logic [1:0] {RX_STEADY, RX_COIN, RX_SPARSE, RX_DENSE} rx_mode_t;

  logic clk;
  logic rst = 1'b1;

  bile_in_if  req_if ();
  bile_out_if rsp_if ();

  bounded_integer_list_engine_top #(.CAPACITY(LIST_CAP)) uut (
    .clk (clk),
    .rst (rst),
    .req (req_if),
    .rsp (rsp_if)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Predictor: a private copy of the list, updated once per accepted request.
  // The entries are kept packed from the head, exactly as the block holds them.
  // ---------------------------------------------------------------------------
  logic signed [VALUE_W-1:0] list_mem [LIST_CAP];
  int unsigned               list_len = 0;
  list_result_t              pending_list_results [$];

  function automatic list_result_t apply_list_action(input logic [ACTION_W-1:0] act,
                                                     input logic signed [VALUE_W-1:0] v);
    list_result_t r;
    int unsigned  pos;
    int unsigned  slot;
    int unsigned  k;
    r = '0;
    pos = list_len;
    slot = 0;
    case (act)
      ACT_PUSH, ACT_INSERT: begin
        if (list_len >= LIST_CAP) begin
          // A full list is left alone and the request is flagged.
          r.rejected = 1'b1;
        end else begin
          // Sorted insert stops at the first entry not smaller than the value,
          // so an equal value lands in front of its twins.
          if (act == ACT_INSERT) begin
            while (slot < list_len && list_mem[slot] < v) slot++;
          end
          for (k = list_len; k > slot; k--) list_mem[k] = list_mem[k-1];
          list_mem[slot] = v;
          list_len++;
          pos = slot;
        end
      end
      ACT_REMOVE, ACT_SEARCH: begin
        // Without a match the scan runs off the end and reports the count.
        while (slot < list_len && list_mem[slot] != v) slot++;
        pos = slot;
        if (slot < list_len) begin
          r.found = 1'b1;
          if (act == ACT_REMOVE) begin
            for (k = slot; k + 1 < list_len; k++) list_mem[k] = list_mem[k+1];
            list_len--;
          end
        end
      end
      ACT_CLEAR: begin
        list_len = 0;
        pos = 0;
      end
      default: begin
      end
    endcase
    r.position    = POS_W'(pos);
    r.entry_count = POS_W'(list_len);
    r.is_empty    = (list_len == 0);
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Result checker. Every transfer on rsp is compared field by field with the
  // oldest prediction; a transfer with nothing pending is a failure as well.
  // ---------------------------------------------------------------------------
  int unsigned mismatch_count = 0;
  int unsigned results_seen = 0;
  int unsigned found_seen = 0;
  int unsigned rejected_seen = 0;
  int unsigned full_seen = 0;

  always @(posedge clk) begin
    list_result_t want;
    list_result_t got;
    if (!rst && rsp_if.valid && rsp_if.ready) begin
      got = '{found: rsp_if.found, position: rsp_if.position,
              entry_count: rsp_if.entry_count, is_empty: rsp_if.is_empty,
              rejected: rsp_if.rejected};
      results_seen++;
      if (got.found) found_seen++;
      if (got.rejected) rejected_seen++;
      if (got.entry_count == POS_W'(LIST_CAP)) full_seen++;
      if (pending_list_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
          $display("%0t: result transfer with nothing pending: found=%0b pos=%0d cnt=%0d",
                   $realtime, got.found, got.position, got.entry_count);
      end else begin
        want = pending_list_results.pop_front();
        if (got.found !== want.found || got.position !== want.position ||
            got.entry_count !== want.entry_count || got.is_empty !== want.is_empty ||
            got.rejected !== want.rejected) begin
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTS)
            $display({"%0t: result %0d differs: expected found=%0b pos=%0d cnt=%0d ",
                      "empty=%0b rej=%0b, got found=%0b pos=%0d cnt=%0d empty=%0b rej=%0b"},
                     $realtime, results_seen, want.found, want.position,
                     want.entry_count, want.is_empty, want.rejected, got.found,
                     got.position, got.entry_count, got.is_empty, got.rejected);
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver. It follows a stall pattern that is picked anew whenever mode_left runs out.
  // Flipping hold_toggle asks for one long hold-off, counted down here, so that
  // the block backs up and stops taking requests.
  // ---------------------------------------------------------------------------
  logic        hold_toggle = 1'b0;
  logic        hold_seen = 1'b0;
  int unsigned hold_left = 0;
  int unsigned mode_left = 0;
  rx_mode_t    rx_mode = RX_STEADY;

  always @(posedge clk) begin
    if (rst) begin
      rsp_if.ready <= 1'b0;
    end else if (hold_toggle != hold_seen) begin
      hold_seen <= hold_toggle;
      hold_left <= HOLD_CYCLES;
      rsp_if.ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      rsp_if.ready <= 1'b0;
    end else begin
      if (mode_left == 0) begin
        rx_mode <= rx_mode_t'($urandom_range(0, 3));
        mode_left <= $urandom_range(32, 200);
      end else begin
        mode_left <= mode_left - 1;
      end
      case (rx_mode)
        RX_STEADY: rsp_if.ready <= 1'b1;
        RX_COIN:   rsp_if.ready <= 1'($urandom_range(0, 1));
        RX_SPARSE: rsp_if.ready <= ($urandom_range(0, 3) == 0);
        default:   rsp_if.ready <= ($urandom_range(0, 3) != 0);
      endcase
    end
  end

  // A run that stops making progress ends here.
  int unsigned cycle_count = 0;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == LIMIT_CYCLES) begin
      $display("Timed out after %0d cycles with %0d results pending.",
               cycle_count, pending_list_results.size());
      $display("*** FAILED ***");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Sender. Requests go out in bursts of random length with random gaps. Each
  // call leaves the task on a rising edge; valid stays high when the burst goes
  // on, so it is never lowered and raised again within one time step.
  // ---------------------------------------------------------------------------
  int unsigned burst_left = 0;
  bit          gaps_off = 1'b0;
  int unsigned sent_count = 0;
  int unsigned action_sent [8];

  task automatic send_item(input logic [ACTION_W-1:0] act,
                           input logic signed [VALUE_W-1:0] v);
    req_if.valid  <= 1'b1;
    req_if.action <= act;
    req_if.value  <= v;
    @(posedge clk);
    while (!req_if.ready) @(posedge clk);
    // The transfer happened at this edge, so the prediction is made now.
    pending_list_results.push_back(apply_list_action(act, v));
    sent_count++;
    action_sent[act]++;
    if (!gaps_off) begin
      if (burst_left != 0) begin
        burst_left--;
      end else begin
        req_if.valid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
        // Now and then a long stretch goes out with no idling at all.
        burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 60)
                                                 : $urandom_range(0, 8);
      end
    end
  endtask

  // Idles the sender until every predicted result has been seen, then lets the
  // block settle for about one full scan.
  task automatic wait_drained();
    req_if.valid <= 1'b0;
    do @(posedge clk); while (pending_list_results.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Picks a value: mostly from a small pool so that matches and duplicates are
  // common, sometimes an extreme, sometimes any 32-bit pattern. With from_list
  // set, an entry that is held right now is chosen most of the time.
  function automatic logic signed [VALUE_W-1:0] pick_value(input bit from_list);
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (from_list && list_len != 0 && roll < 70)
      return list_mem[$urandom_range(0, list_len - 1)];
    roll = $urandom_range(0, 99);
    if (roll < 55) return VALUE_W'($urandom_range(0, 15)) - 32'sd8;
    if (roll < 70) begin
      case ($urandom_range(0, 5))
        0: return VAL_MIN;
        1: return VAL_MIN + 1;
        2: return VAL_MAX;
        3: return VAL_MAX - 1;
        4: return 32'sd0;
        default: return -32'sd1;
      endcase
    end
    return $urandom();
  endfunction

  // ---------------------------------------------------------------------------
  // Tests.
  // ---------------------------------------------------------------------------

  // Each action once or more on a short list: extremes of the value, equal
  // values on insert, misses on remove and search, and the spare codes.
  task automatic test_directed_actions();
    logic [ACTION_W-1:0] spare;
    send_item(ACT_CLEAR, 32'sd0);
    send_item(ACT_SEARCH, 32'sd5);
    send_item(ACT_REMOVE, 32'sd5);
    send_item(ACT_PUSH, VAL_MAX);
    send_item(ACT_PUSH, VAL_MIN);
    send_item(ACT_INSERT, 32'sd0);
    send_item(ACT_INSERT, 32'sd0);
    send_item(ACT_INSERT, -32'sd1);
    send_item(ACT_INSERT, 32'shAAAA_AAAA);
    send_item(ACT_INSERT, 32'sh5555_5555);
    send_item(ACT_PUSH, -32'sd1);
    send_item(ACT_SEARCH, VAL_MIN);
    send_item(ACT_SEARCH, 32'sd12345);
    send_item(ACT_REMOVE, 32'sd0);
    send_item(ACT_REMOVE, VAL_MAX);
    send_item(ACT_REMOVE, 32'sd777);
    for (spare = ACT_SPARE_FIRST; spare != ACT_SPARE_FIRST - 1; spare++) begin
      send_item(spare, $urandom());
      if (spare == ACT_SPARE_LAST) break;
    end
    send_item(ACT_SEARCH, -32'sd1);
    send_item(ACT_CLEAR, 32'sd0);
    send_item(ACT_CLEAR, 32'sd0);
    wait_drained();
  endtask

  // Fills the list to its limit, checks that push and insert are rejected while
  // full, and works at both ends of a full list.
  task automatic test_full_list();
    int unsigned n;
    send_item(ACT_CLEAR, 32'sd0);
    for (n = 0; n < LIST_CAP; n++) send_item(ACT_INSERT, pick_value(1'b0));
    send_item(ACT_PUSH, 32'sd1);
    send_item(ACT_INSERT, VAL_MIN);
    send_item(ACT_SEARCH, list_mem[LIST_CAP - 1]);
    send_item(ACT_REMOVE, list_mem[LIST_CAP - 1]);
    send_item(ACT_PUSH, VAL_MAX);
    send_item(ACT_INSERT, 32'sd3);
    send_item(ACT_SEARCH, list_mem[0]);
    send_item(ACT_REMOVE, list_mem[0]);
    send_item(ACT_SPARE_LAST, 32'sd0);
    send_item(ACT_CLEAR, 32'sd0);
    wait_drained();
  endtask

  // The receiver holds off for a long time while requests keep coming back to
  // back, so the result register and S_DONE both fill up and req.ready drops.
  task automatic test_output_stall();
    int unsigned n;
    gaps_off = 1'b1;
    hold_toggle <= ~hold_toggle;
    for (n = 0; n < 30; n++) send_item(($urandom_range(0, 1) != 0) ? ACT_PUSH
                                                                   : ACT_INSERT,
                                       pick_value(1'b0));
    for (n = 0; n < 10; n++) send_item(ACT_SEARCH, pick_value(1'b1));
    gaps_off = 1'b0;
    burst_left = 0;
    wait_drained();
  endtask

  // Random traffic in phases that grow, shrink or churn the list, so that it
  // passes through empty and full many times. Noise is a few spare codes and
  // the occasional clear.
  task automatic test_random_traffic();
    int unsigned n;
    int unsigned bias;
    int unsigned roll;
    bias = 0;
    for (n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 120 == 0) bias = $urandom_range(0, 2);
      roll = $urandom_range(0, 99);
      if (roll < 3) begin
        send_item(ACT_SPARE_FIRST + 3'($urandom_range(0, 2)), $urandom());
      end else if (roll < 5) begin
        send_item(ACT_CLEAR, $urandom());
      end else begin
        roll = $urandom_range(0, 99);
        // Growing phases favor push and insert, shrinking ones favor remove.
        if (roll < ((bias == 0) ? 75 : (bias == 1) ? 25 : 45))
          send_item(($urandom_range(0, 2) == 0) ? ACT_PUSH : ACT_INSERT, pick_value(1'b0));
        else if ($urandom_range(0, 99) < ((bias == 1) ? 70 : 50))
          send_item(ACT_REMOVE, pick_value(1'b1));
        else
          send_item(ACT_SEARCH, pick_value(1'b1));
      end
    end
    wait_drained();
  endtask

  initial begin
    req_if.valid  <= 1'b0;
    req_if.action <= ACT_PUSH;
    req_if.value  <= '0;
    foreach (action_sent[i]) action_sent[i] = 0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed_actions();
    test_full_list();
    test_output_stall();
    test_random_traffic();

    $display("Sent %0d requests (push %0d, insert %0d, remove %0d, search %0d, clear %0d).",
             sent_count, action_sent[ACT_PUSH], action_sent[ACT_INSERT],
             action_sent[ACT_REMOVE], action_sent[ACT_SEARCH], action_sent[ACT_CLEAR]);
    $display("Checked %0d results: %0d matches found, %0d rejects, %0d at full, %0d errors.",
             results_seen, found_seen, rejected_seen, full_seen, mismatch_count);
    if (mismatch_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// File: files.f
hw/rtl/bile_pkg.sv
hw/rtl/bile_if.sv
hw/rtl/bile_ram.sv
hw/rtl/bounded_integer_list_engine_top.sv
tb/tb_bounded_integer_list_engine_top.sv
